/* rtl/core/brainfuck_machine_step_assert.svh */
// Assertion macros for the step machine.
`ifndef BRAINFUCK_MACHINE_STEP_ASSERT_SVH
`define BRAINFUCK_MACHINE_STEP_ASSERT_SVH

`ifndef SYNTH
`define BFM_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
`define BFM_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define BFM_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg)
`define BFM_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

/* rtl/core/bfm_pkg.sv */
`timescale 1ns / 1ps
package bfm_pkg;

    localparam int DATA_CELLS = 4096;
    localparam int PROG_DEPTH = 4096;
    localparam int NEST_DEPTH = 64;

    localparam int PA_W   = $clog2(PROG_DEPTH);
    localparam int IP_W   = $clog2(PROG_DEPTH + 1);
    localparam int DA_W   = $clog2(DATA_CELLS);
    localparam int FILL_W = $clog2(DATA_CELLS + 1);
    localparam int CNT_W  = $clog2(NEST_DEPTH + 1);

    localparam logic [1:0] REQ_CLEAR  = 2'd0;
    localparam logic [1:0] REQ_APPEND = 2'd1;
    localparam logic [1:0] REQ_STEP   = 2'd2;

    typedef enum logic [2:0] {
        OP_INC   = 3'd0,
        OP_DEC   = 3'd1,
        OP_RIGHT = 3'd2,
        OP_LEFT  = 3'd3,
        OP_OPEN  = 3'd4,
        OP_CLOSE = 3'd5,
        OP_IN    = 3'd6,
        OP_OUT   = 3'd7
    } op_e_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_HALT      = 3'd1,
        ST_UNMATCHED = 3'd2,
        ST_RANGE     = 3'd3,
        ST_FULL      = 3'd4,
        ST_DEEP      = 3'd5
    } status_e_t;

    typedef struct packed {
        logic       is_cmd;
        op_e_t      op;
    } cmd_t;

    // link: partner bracket, or the enclosing open bracket while still open
    typedef struct packed {
        op_e_t             op;
        logic [PA_W-1:0]   link;
    } prog_word_t;

    typedef struct packed {
        logic [1:0] req_type;
        logic [7:0] prog_char;
        logic [7:0] in_byte;
    } in_item_t;

    typedef struct packed {
        logic        out_valid;
        logic [7:0]  out_byte;
        logic        took_input;
        logic [2:0]  status;
        logic [12:0] instr_index;
        logic [11:0] tape_pos;
    } out_item_t;

    function automatic cmd_t encode_char(input logic [7:0] c);
        cmd_t r;
        r.is_cmd = 1'b1;
        r.op     = OP_INC;
        unique case (c)
            8'h2B:   r.op = OP_INC;
            8'h2D:   r.op = OP_DEC;
            8'h3E:   r.op = OP_RIGHT;
            8'h3C:   r.op = OP_LEFT;
            8'h5B:   r.op = OP_OPEN;
            8'h5D:   r.op = OP_CLOSE;
            8'h2C:   r.op = OP_IN;
            8'h2E:   r.op = OP_OUT;
            default: r.is_cmd = 1'b0;
        endcase
        return r;
    endfunction

endpackage

/* rtl/core/brainfuck_machine_step.sv */
`timescale 1ns / 1ps
// Step machine for the eight-command tape language.
// Input channel s_valid/s_ready/s_data carries one request per item: clear,
// append one program character, or execute one instruction. Every item
// yields exactly one result item on m_valid/m_ready/m_data.
// An item is accepted in the idle state, where program and data memories are
// read; the result register loads from the execute state, which holds while
// an earlier result waits unread. Appending a closing bracket passes through
// the extra fix state, which writes the partner back into the program memory
// through its single write port.
// The output register frees the input side: the next item is accepted while
// a result waits. If the receiver still stalls when that next item is
// finished, execution holds until m_ready takes the waiting result.
// Reset (aresetn low, synchronous) and a clear request empty the program and
// zero pointers and the fault. Data cells read as zero at or above a fill
// mark that clear resets, so no clearing pass runs; the block is ready as
// soon as reset is released.
module brainfuck_machine_step
    import bfm_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

`include "brainfuck_machine_step_assert.svh"

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_FIX
    } state_t;

    state_t            state_reg, state_next;
    in_item_t          item_reg;
    logic [IP_W-1:0]   len_reg, len_next;
    logic [IP_W-1:0]   ip_reg, ip_next;
    logic [DA_W-1:0]   dp_reg, dp_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [PA_W-1:0]   top_reg, top_next;
    status_e_t         fault_reg, fault_next;
    logic [PA_W-1:0]   fix_addr_reg, fix_addr_next;
    logic [PA_W-1:0]   fix_link_reg, fix_link_next;
    logic              m_valid_reg, m_valid_next;
    out_item_t         m_data_reg, m_data_next;

    logic              accept;
    logic              proceed;
    logic              prog_we;
    logic [PA_W-1:0]   prog_waddr;
    prog_word_t        prog_wdata;
    logic [PA_W-1:0]   prog_raddr;
    prog_word_t        prog_rdata;
    logic              cell_we;
    logic [7:0]        cell_wdata;
    logic [7:0]        cell_rdata;

    assign s_ready = (state_reg == S_IDLE);
    assign accept  = s_valid && s_ready;
    assign proceed = (state_reg == S_EXEC) && (!m_valid_reg || m_ready);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    assign prog_raddr = (s_data.req_type == REQ_APPEND) ? top_reg : ip_reg[PA_W-1:0];

    bfm_ram #(
        .DEPTH (PROG_DEPTH),
        .WIDTH ($bits(prog_word_t))
    ) u_prog_ram (
        .aclk    (aclk),
        .wr_en   (prog_we),
        .wr_addr (prog_waddr),
        .wr_data (prog_wdata),
        .rd_en   (accept),
        .rd_addr (prog_raddr),
        .rd_data (prog_rdata)
    );

    bfm_ram #(
        .DEPTH (DATA_CELLS),
        .WIDTH (8)
    ) u_cell_ram (
        .aclk    (aclk),
        .wr_en   (cell_we),
        .wr_addr (dp_reg),
        .wr_data (cell_wdata),
        .rd_en   (accept),
        .rd_addr (dp_reg),
        .rd_data (cell_rdata)
    );

    always_comb begin
        cmd_t       cmd;
        logic [7:0] cur_byte;
        logic       cell_ok;

        state_next    = state_reg;
        len_next      = len_reg;
        ip_next       = ip_reg;
        dp_next       = dp_reg;
        fill_next     = fill_reg;
        cnt_next      = cnt_reg;
        top_next      = top_reg;
        fault_next    = fault_reg;
        fix_addr_next = fix_addr_reg;
        fix_link_next = fix_link_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_data_next   = m_data_reg;
        prog_we       = 1'b0;
        prog_waddr    = len_reg[PA_W-1:0];
        prog_wdata    = '{op: OP_INC, link: '0};
        cell_we       = 1'b0;
        cell_wdata    = 8'd0;

        cmd      = encode_char(item_reg.prog_char);
        cell_ok  = FILL_W'(dp_reg) < fill_reg;
        cur_byte = cell_ok ? cell_rdata : 8'd0;

        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                if (proceed) begin
                    state_next              = S_IDLE;
                    m_valid_next            = 1'b1;
                    m_data_next             = '0;
                    m_data_next.status      = fault_reg;
                    unique case (item_reg.req_type)
                        REQ_CLEAR: begin
                            len_next           = '0;
                            ip_next            = '0;
                            dp_next            = '0;
                            fill_next          = '0;
                            cnt_next           = '0;
                            fault_next         = ST_OK;
                            m_data_next.status = ST_OK;
                        end
                        REQ_APPEND: begin
                            if (fault_reg != ST_OK) begin
                                m_data_next.status = fault_reg;
                            end else if (!cmd.is_cmd) begin
                                m_data_next.status = ST_OK;
                            end else if (len_reg >= IP_W'(PROG_DEPTH)) begin
                                fault_next         = ST_FULL;
                                m_data_next.status = ST_FULL;
                            end else if (cmd.op == OP_OPEN
                                         && cnt_reg >= CNT_W'(NEST_DEPTH)) begin
                                fault_next         = ST_DEEP;
                                m_data_next.status = ST_DEEP;
                            end else if (cmd.op == OP_CLOSE && cnt_reg == '0) begin
                                fault_next         = ST_UNMATCHED;
                                m_data_next.status = ST_UNMATCHED;
                            end else begin
                                m_data_next.status = ST_OK;
                                prog_we            = 1'b1;
                                prog_wdata.op      = cmd.op;
                                len_next           = len_reg + IP_W'(1);
                                if (cmd.op == OP_OPEN) begin
                                    // push: link to the enclosing open bracket
                                    prog_wdata.link = top_reg;
                                    top_next        = len_reg[PA_W-1:0];
                                    cnt_next        = cnt_reg + CNT_W'(1);
                                end else if (cmd.op == OP_CLOSE) begin
                                    // pop: follow the link read at accept
                                    prog_wdata.link = top_reg;
                                    top_next        = prog_rdata.link;
                                    cnt_next        = cnt_reg - CNT_W'(1);
                                    fix_addr_next   = top_reg;
                                    fix_link_next   = len_reg[PA_W-1:0];
                                    state_next      = S_FIX;
                                end
                            end
                        end
                        REQ_STEP: begin
                            if (fault_reg != ST_OK) begin
                                m_data_next.status = fault_reg;
                            end else if (cnt_reg != '0) begin
                                fault_next         = ST_UNMATCHED;
                                m_data_next.status = ST_UNMATCHED;
                            end else if (ip_reg >= len_reg) begin
                                m_data_next.status = ST_HALT;
                            end else begin
                                m_data_next.status = ST_OK;
                                ip_next            = ip_reg + IP_W'(1);
                                cell_we            = 1'b1;
                                cell_wdata         = cur_byte;
                                if (FILL_W'(dp_reg) == fill_reg) begin
                                    fill_next = fill_reg + FILL_W'(1);
                                end
                                unique case (prog_rdata.op)
                                    OP_INC: cell_wdata = cur_byte + 8'd1;
                                    OP_DEC: cell_wdata = cur_byte - 8'd1;
                                    OP_RIGHT: begin
                                        if (dp_reg == DA_W'(DATA_CELLS - 1)) begin
                                            fault_next         = ST_RANGE;
                                            m_data_next.status = ST_RANGE;
                                            ip_next            = ip_reg;
                                        end else begin
                                            dp_next = dp_reg + DA_W'(1);
                                        end
                                    end
                                    OP_LEFT: begin
                                        if (dp_reg == '0) begin
                                            fault_next         = ST_RANGE;
                                            m_data_next.status = ST_RANGE;
                                            ip_next            = ip_reg;
                                        end else begin
                                            dp_next = dp_reg - DA_W'(1);
                                        end
                                    end
                                    OP_OPEN: begin
                                        if (cur_byte == 8'd0) begin
                                            ip_next = IP_W'(prog_rdata.link) + IP_W'(1);
                                        end
                                    end
                                    OP_CLOSE: begin
                                        if (cur_byte != 8'd0) begin
                                            ip_next = IP_W'(prog_rdata.link) + IP_W'(1);
                                        end
                                    end
                                    OP_IN: begin
                                        cell_wdata             = item_reg.in_byte;
                                        m_data_next.took_input = 1'b1;
                                    end
                                    OP_OUT: begin
                                        m_data_next.out_valid = 1'b1;
                                        m_data_next.out_byte  = cur_byte;
                                    end
                                endcase
                            end
                        end
                        default: m_data_next.status = fault_reg;
                    endcase
                    m_data_next.instr_index = 13'(ip_next);
                    m_data_next.tape_pos    = 12'(dp_next);
                end
            end
            S_FIX: begin
                // point the open bracket at its closing partner
                prog_we         = 1'b1;
                prog_waddr      = fix_addr_reg;
                prog_wdata.op   = OP_OPEN;
                prog_wdata.link = fix_link_reg;
                state_next      = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            len_reg     <= '0;
            ip_reg      <= '0;
            dp_reg      <= '0;
            fill_reg    <= '0;
            cnt_reg     <= '0;
            top_reg     <= '0;
            fault_reg   <= ST_OK;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            len_reg     <= len_next;
            ip_reg      <= ip_next;
            dp_reg      <= dp_next;
            fill_reg    <= fill_next;
            cnt_reg     <= cnt_next;
            top_reg     <= top_next;
            fault_reg   <= fault_next;
            m_valid_reg <= m_valid_next;
        end
        if (accept) begin
            item_reg <= s_data;
        end
        fix_addr_reg <= fix_addr_next;
        fix_link_reg <= fix_link_next;
        m_data_reg   <= m_data_next;
    end

    `BFM_ASSERT_IMPL(a_dp_fill, aclk, aresetn, 1'b1, FILL_W'(dp_reg) <= fill_reg, "dp past fill")
    `BFM_ASSERT_IMPL(a_ip_in_prog, aclk, aresetn, 1'b1, ip_reg <= len_reg, "ip past program end")
    `BFM_ASSERT_IMPL(a_nest, aclk, aresetn, 1'b1, cnt_reg <= CNT_W'(NEST_DEPTH), "nest overflow")
    `BFM_ASSERT_NEXT(a_fix, aclk, aresetn, state_reg == S_FIX, state_reg == S_IDLE, "fix stuck")
    `BFM_ASSERT_IMPL(a_stall, aclk, aresetn, !proceed, !cell_we, "cell write while stalled")

endmodule

/* rtl/core/bfm_ram.sv */
`timescale 1ns / 1ps
module bfm_ram #(
    parameter int DEPTH = 4096,
    parameter int WIDTH = 8,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
